/* hw/rtl/adam_pkg.sv */
package adam_pkg;

    localparam int WEIGHT_DEPTH_DEF = 4096;

    localparam int IDX_W   = 12;
    localparam int DATA_W  = 32;
    localparam int MOM2_W  = 48;
    localparam int BETA_W  = 16;
    localparam int LR_W    = 24;
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 5;

    localparam logic [LR_W-1:0]   LEARN_RATE_RST = 24'd16777;
    localparam logic [BETA_W-1:0] BETA_ONE_RST   = 16'd58982;
    localparam logic [BETA_W-1:0] BETA_TWO_RST   = 16'd65470;
    localparam logic [MOM2_W-1:0] EPS_VALUE_RST  = 48'd109951;

    // one in Q0.32, saturated
    localparam logic [31:0] POWER_ONE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_LEARN_RATE = 2'd0,
        REG_BETA_ONE   = 2'd1,
        REG_BETA_TWO   = 2'd2,
        REG_EPS_VALUE  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        DIV_Q32 = 1'b0,
        DIV_Q35 = 1'b1
    } div_mode_t;

    typedef struct packed {
        logic [IDX_W-1:0]         elem_index;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] weight_in;
        logic                     step_start;
    } adam_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         index_out;
        logic signed [DATA_W-1:0] weight_out;
        logic                     saturated;
    } adam_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef struct packed {
        logic        start;
        div_mode_t   mode;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [34:0] quotient;
    } div_rsp_t;

endpackage

/* hw/rtl/adam_stream_if.sv */
interface adam_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/adam_isqrt.sv */
// Floor square root of a 64-bit radicand, two radicand bits per cycle.
module adam_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adam_pkg::sqrt_req_t   req,
    output adam_pkg::sqrt_rsp_t   rsp
);
    localparam int ITER = 32;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;
    logic [35:0] rem_diff;
    logic [33:0] rem_next;
    logic [31:0] root_next;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_sh >= trial);
        rem_diff  = take ? (rem_sh - trial) : rem_sh;
        rem_next  = rem_diff[33:0];
        root_next = {root_reg[30:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= 5'(ITER - 1);
                rad_reg  <= req.radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[61:0], 2'b00};
                rem_reg  <= rem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg - 5'd1;
                done_reg <= (cnt_reg == '0);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

/* hw/rtl/adam_div.sv */
// Restoring divider, one quotient bit per cycle. The quotient is 32 or 35
// bits; a larger quotient is flagged as overflow at start.
module adam_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  adam_pkg::div_req_t   req,
    output adam_pkg::div_rsp_t   rsp
);
    logic        busy_reg;
    logic        done_reg;
    logic        ovf_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] lo_reg;
    logic [32:0] rem_reg;
    logic [32:0] div_reg;
    logic [34:0] q_reg;

    logic [32:0] hi_start;
    logic [63:0] lo_start;
    logic [5:0]  cnt_start;
    logic [33:0] rem_sh;
    logic        ge;
    logic [33:0] rem_diff;

    always_comb
    begin
        if (req.mode == adam_pkg::DIV_Q35)
        begin
            hi_start  = 33'(req.dividend[63:35]);
            lo_start  = {req.dividend[34:0], 29'd0};
            cnt_start = 6'd34;
        end
        else
        begin
            hi_start  = 33'(req.dividend[63:32]);
            lo_start  = {req.dividend[31:0], 32'd0};
            cnt_start = 6'd31;
        end
        rem_sh   = {rem_reg, lo_reg[63]};
        ge       = (rem_sh >= {1'b0, div_reg});
        rem_diff = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            lo_reg   <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            if (req.start)
            begin
                div_reg <= req.divisor;
                rem_reg <= hi_start;
                lo_reg  <= lo_start;
                cnt_reg <= cnt_start;
                q_reg   <= '0;
                if (hi_start >= req.divisor)
                begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end
                else
                begin
                    ovf_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                lo_reg   <= {lo_reg[62:0], 1'b0};
                rem_reg  <= rem_diff[32:0];
                q_reg    <= {q_reg[33:0], ge};
                cnt_reg  <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == '0);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.ovf      = ovf_reg;
    assign rsp.quotient = q_reg;
endmodule

/* hw/rtl/adam_weight_update_core.sv */
// Flow: a request runs through the bit-serial root and then the divider;
//   one that opens a new step runs through both once before that. An index
//   past the stores skips both unless it opens a step. One request is in
//   flight at a time, so a new request is taken only once the last result
//   has been loaded into the output register.
// Reset: control and configuration registers take their defaults; then a
//   clearing pass zeroes both moment stores before any request is taken.
module adam_weight_update_core #(
    parameter int WEIGHT_DEPTH = adam_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    adam_stream_if.sink                         grad_ch,
    adam_stream_if.source                       wt_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adam_pkg::PADDR_W-1:0]        paddr,
    input  logic [adam_pkg::PDATA_W-1:0]        pwdata,
    output logic [adam_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    localparam int ADDR_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int EXT_W  = ((ADDR_W > adam_pkg::IDX_W) ? ADDR_W : adam_pkg::IDX_W) + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POW,
        S_RSQ_WAIT,
        S_RMUL,
        S_RDIV_WAIT,
        S_MUL1,
        S_MUL2,
        S_MOM,
        S_VSQ_WAIT,
        S_MUL3,
        S_QDIV_WAIT,
        S_FIN,
        S_OUT
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [adam_pkg::LR_W-1:0]   learn_rate_reg;
    logic [adam_pkg::BETA_W-1:0] beta_one_reg;
    logic [adam_pkg::BETA_W-1:0] beta_two_reg;
    logic [adam_pkg::MOM2_W-1:0] eps_value_reg;
    adam_pkg::cfg_reg_t          cfg_sel;
    logic                        cfg_we;

    assign cfg_sel = adam_pkg::cfg_reg_t'(paddr[4:3]);
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= adam_pkg::LEARN_RATE_RST;
            beta_one_reg   <= adam_pkg::BETA_ONE_RST;
            beta_two_reg   <= adam_pkg::BETA_TWO_RST;
            eps_value_reg  <= adam_pkg::EPS_VALUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                adam_pkg::REG_LEARN_RATE: learn_rate_reg <= pwdata[adam_pkg::LR_W-1:0];
                adam_pkg::REG_BETA_ONE:   beta_one_reg   <= pwdata[adam_pkg::BETA_W-1:0];
                adam_pkg::REG_BETA_TWO:   beta_two_reg   <= pwdata[adam_pkg::BETA_W-1:0];
                adam_pkg::REG_EPS_VALUE:  eps_value_reg  <= pwdata[adam_pkg::MOM2_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            adam_pkg::REG_LEARN_RATE: prdata = 64'(learn_rate_reg);
            adam_pkg::REG_BETA_ONE:   prdata = 64'(beta_one_reg);
            adam_pkg::REG_BETA_TWO:   prdata = 64'(beta_two_reg);
            adam_pkg::REG_EPS_VALUE:  prdata = 64'(eps_value_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Control and datapath registers
    // ---------------------------------------------------------------
    state_t                      state_reg;
    logic [ADDR_W-1:0]           clr_ptr_reg;

    logic [adam_pkg::IDX_W-1:0]  idx_reg;
    logic signed [31:0]          grad_reg;
    logic signed [31:0]          w_in_reg;
    logic                        in_range_reg;
    logic                        sat_reg;

    logic [31:0]                 step_count_reg;
    logic [31:0]                 b1_pow_reg;
    logic [31:0]                 b2_pow_reg;
    logic [31:0]                 clr_rate_reg;
    logic [31:0]                 s_root_reg;

    logic signed [48:0]          pm1_reg;
    logic signed [49:0]          pm2_reg;
    logic [63:0]                 gsq_reg;
    logic [63:0]                 pv1_reg;
    logic [64:0]                 pv2_reg;
    logic signed [31:0]          m_new_reg;
    logic [33:0]                 delta_reg;

    logic signed [31:0]          res_w_reg;
    logic                        res_sat_reg;
    logic                        out_valid_reg;
    adam_pkg::adam_rsp_t         out_pay_reg;

    adam_pkg::sqrt_req_t         sq_req_reg;
    adam_pkg::sqrt_rsp_t         sq_rsp;
    adam_pkg::div_req_t          dv_req_reg;
    adam_pkg::div_rsp_t          dv_rsp;

    // Moment stores, one read at request time and one write per update
    logic signed [31:0]          m_mem [WEIGHT_DEPTH];
    logic [47:0]                 v_mem [WEIGHT_DEPTH];
    logic signed [31:0]          m_rd_reg;
    logic [47:0]                 v_rd_reg;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic                        req_acc;
    logic [EXT_W-1:0]            idx_ext;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        idx_ok;
    logic                        out_load;

    logic [31:0]                 b1_pow_next;
    logic [31:0]                 b2_pow_next;
    logic [32:0]                 d2_next;
    logic [32:0]                 d1;
    logic [55:0]                 lr_s;

    logic signed [16:0]          b1_s;
    logic signed [17:0]          omb1_s;
    logic [16:0]                 omb2;
    logic [31:0]                 g_mag;
    logic signed [50:0]          m_sum;
    logic [55:0]                 sq_full;
    logic [47:0]                 sq_clip;
    logic                        sq_ovf;
    logic [65:0]                 v_sum;
    logic [47:0]                 v_new;
    logic [48:0]                 v_eps;
    logic [31:0]                 m_mag;
    logic [32:0]                 r_div;
    logic [34:0]                 q_big;
    logic signed [34:0]          w_sum;

    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_wa;
    logic signed [31:0]          m_wd;
    logic [47:0]                 v_wd;

    assign grad_ch.ready = (state_reg == S_IDLE);
    assign req_acc       = grad_ch.valid && grad_ch.ready;
    assign idx_ext       = EXT_W'(grad_ch.payload.elem_index);
    assign rd_addr       = idx_ext[ADDR_W-1:0];
    assign idx_ok        = (idx_ext < EXT_W'(WEIGHT_DEPTH));
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || wt_ch.ready);

    always_comb
    begin
        // running powers of the betas and the rate-correction operands
        b1_pow_next = 32'((64'(b1_pow_reg) * 64'(beta_one_reg)) >> 16);
        b2_pow_next = 32'((64'(b2_pow_reg) * 64'(beta_two_reg)) >> 16);
        d2_next     = 33'h1_0000_0000 - 33'(b2_pow_next);
        d1          = 33'h1_0000_0000 - 33'(b1_pow_reg);
        lr_s        = 56'(learn_rate_reg) * 56'(s_root_reg);

        // moment arithmetic
        b1_s    = $signed({1'b0, beta_one_reg});
        omb1_s  = $signed({1'b0, 17'h1_0000 - 17'(beta_one_reg)});
        omb2    = 17'h1_0000 - 17'(beta_two_reg);
        g_mag   = grad_reg[31] ? 32'(-grad_reg) : 32'(grad_reg);
        m_sum   = {{2{pm1_reg[48]}}, pm1_reg} + {pm2_reg[49], pm2_reg};
        sq_full = gsq_reg[63:8];
        sq_ovf  = (sq_full[55:48] != '0);
        sq_clip = sq_ovf ? 48'hFFFF_FFFF_FFFF : sq_full[47:0];
        v_sum   = 66'(pv1_reg) + 66'(pv2_reg);
        v_new   = v_sum[63:16];
        v_eps   = 49'(v_new) + 49'(eps_value_reg);

        // step size and weight update
        m_mag  = m_new_reg[31] ? 32'(-m_new_reg) : 32'(m_new_reg);
        r_div  = (sq_rsp.root == '0) ? 33'd1 : 33'(sq_rsp.root);
        q_big  = dv_rsp.quotient;
        w_sum  = m_new_reg[31] ? (35'(w_in_reg) + $signed({1'b0, delta_reg}))
                               : (35'(w_in_reg) - $signed({1'b0, delta_reg}));

        // store write port: clearing pass, then moment write-back
        mem_we = 1'b0;
        mem_wa = clr_ptr_reg;
        m_wd   = '0;
        v_wd   = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_MOM) && in_range_reg)
        begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(idx_reg);
            m_wd   = m_new_reg;
            v_wd   = v_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[mem_wa] <= m_wd;
            v_mem[mem_wa] <= v_wd;
        end
        if (req_acc)
        begin
            m_rd_reg <= m_mem[rd_addr];
            v_rd_reg <= v_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_ptr_reg    <= '0;
            step_count_reg <= '0;
            b1_pow_reg     <= adam_pkg::POWER_ONE;
            b2_pow_reg     <= adam_pkg::POWER_ONE;
            clr_rate_reg   <= '0;
            out_valid_reg  <= 1'b0;
            sq_req_reg     <= '0;
            dv_req_reg     <= '0;
            in_range_reg   <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            // start requests to the serial units last one cycle
            sq_req_reg.start <= (state_reg == S_POW) || (state_reg == S_MOM);
            dv_req_reg.start <= (state_reg == S_RMUL) || (state_reg == S_MUL3);

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wt_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + ADDR_W'(1);
                    if (clr_ptr_reg == ADDR_W'(WEIGHT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (req_acc)
                    begin
                        idx_reg      <= grad_ch.payload.elem_index;
                        grad_reg     <= grad_ch.payload.gradient;
                        w_in_reg     <= grad_ch.payload.weight_in;
                        in_range_reg <= idx_ok;
                        sat_reg      <= 1'b0;
                        if (grad_ch.payload.step_start)
                        begin
                            state_reg <= S_POW;
                        end
                        else if (idx_ok)
                        begin
                            state_reg <= S_MUL1;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                // advance the step: powers, then sqrt(1 - b2^t) in Q0.31
                S_POW:
                begin
                    step_count_reg      <= step_count_reg + 32'd1;
                    b1_pow_reg          <= b1_pow_next;
                    b2_pow_reg          <= b2_pow_next;
                    sq_req_reg.radicand <= 64'({d2_next, 30'd0});
                    state_reg           <= S_RSQ_WAIT;
                end

                S_RSQ_WAIT:
                begin
                    if (sq_rsp.done)
                    begin
                        s_root_reg <= sq_rsp.root;
                        state_reg  <= S_RMUL;
                    end
                end

                // clr = 2*lr*s / (1 - b1^t)
                S_RMUL:
                begin
                    dv_req_reg.mode     <= adam_pkg::DIV_Q32;
                    dv_req_reg.dividend <= {7'd0, lr_s, 1'b0};
                    dv_req_reg.divisor  <= d1;
                    state_reg           <= S_RDIV_WAIT;
                end

                S_RDIV_WAIT:
                begin
                    if (dv_rsp.done)
                    begin
                        clr_rate_reg <= dv_rsp.ovf ? 32'hFFFF_FFFF : q_big[31:0];
                        sat_reg      <= dv_rsp.ovf;
                        state_reg    <= in_range_reg ? S_MUL1 : S_FIN;
                    end
                end

                S_MUL1:
                begin
                    pm1_reg   <= m_rd_reg * b1_s;
                    pm2_reg   <= grad_reg * omb1_s;
                    gsq_reg   <= 64'(g_mag) * 64'(g_mag);
                    pv1_reg   <= 64'(v_rd_reg) * 64'(beta_two_reg);
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    m_new_reg <= m_sum[47:16];
                    pv2_reg   <= 65'(sq_clip) * 65'(omb2);
                    if (sq_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= S_MOM;
                end

                // write back the moments and start sqrt(v + eps) in Q.24
                S_MOM:
                begin
                    sq_req_reg.radicand <= 64'({v_eps, 8'd0});
                    state_reg           <= S_VSQ_WAIT;
                end

                S_VSQ_WAIT:
                begin
                    if (sq_rsp.done)
                    begin
                        state_reg <= S_MUL3;
                    end
                end

                // step magnitude = clr * |m| / r; r is still on the root output
                S_MUL3:
                begin
                    dv_req_reg.mode     <= adam_pkg::DIV_Q35;
                    dv_req_reg.dividend <= 64'(clr_rate_reg) * 64'(m_mag);
                    dv_req_reg.divisor  <= r_div;
                    state_reg           <= S_QDIV_WAIT;
                end

                S_QDIV_WAIT:
                begin
                    if (dv_rsp.done)
                    begin
                        if (dv_rsp.ovf || (q_big > 35'h2_0000_0000))
                        begin
                            delta_reg <= 34'h2_0000_0000;
                        end
                        else
                        begin
                            delta_reg <= q_big[33:0];
                        end
                        state_reg <= S_FIN;
                    end
                end

                // apply the step, clip to signed 32 bits; out of range keeps the weight
                S_FIN:
                begin
                    if (!in_range_reg)
                    begin
                        res_w_reg   <= w_in_reg;
                        res_sat_reg <= 1'b0;
                    end
                    else if (w_sum > 35'sh0_7FFF_FFFF)
                    begin
                        res_w_reg   <= 32'sh7FFF_FFFF;
                        res_sat_reg <= 1'b1;
                    end
                    else if (w_sum < -35'sh0_8000_0000)
                    begin
                        res_w_reg   <= 32'sh8000_0000;
                        res_sat_reg <= 1'b1;
                    end
                    else
                    begin
                        res_w_reg   <= w_sum[31:0];
                        res_sat_reg <= sat_reg;
                    end
                    state_reg <= S_OUT;
                end

                // hold the result until the output register frees up
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_pay_reg.index_out  <= idx_reg;
                        out_pay_reg.weight_out <= res_w_reg;
                        out_pay_reg.saturated  <= res_sat_reg;
                        state_reg              <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign wt_ch.valid   = out_valid_reg;
    assign wt_ch.payload = out_pay_reg;

    adam_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req_reg),
        .rsp   (sq_rsp)
    );

    adam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req_reg),
        .rsp   (dv_rsp)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_store_write_only_clear_or_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) || ((state_reg == S_MOM) && in_range_reg))
    ) else $error("moment store written outside clear or update");

    a_request_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg != S_IDLE)
    ) else $error("sequencer stayed idle after taking a request");

    a_out_of_range_passes_weight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_load && !in_range_reg) |=>
            ((wt_ch.payload.weight_out == $past(w_in_reg)) && !wt_ch.payload.saturated)
    ) else $error("out-of-range index changed the weight");

    a_rate_kept_on_plain_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1) |=> $stable(clr_rate_reg)
    ) else $error("corrected rate moved during a moment update");
endmodule
